>>> rtl/phh_pkg.sv
// Shared types, constants and helpers for the pulse-height histogrammer.
package phh_pkg;

  localparam int unsigned NUM_BINS_DEF = 4096;
  localparam int unsigned SUM_W        = 40;
  localparam int unsigned ENERGY_W     = 32;
  localparam int unsigned COUNT_W      = 32;
  localparam int unsigned BW_W         = 32;
  localparam int unsigned BINS_USED_W  = 13;
  localparam int unsigned BIN_IDX_W    = 12;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 40;

  localparam logic [BW_W-1:0]        BIN_WIDTH_RST = BW_W'(256);
  localparam logic [SUM_W-1:0]       PEAK_LOW_RST  = '0;
  localparam logic [SUM_W-1:0]       PEAK_HIGH_RST = '0;
  localparam logic [BINS_USED_W-1:0] BINS_USED_RST = BINS_USED_W'(4096);

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_ADD   = 2'd1,
    OP_END   = 2'd2,
    OP_READ  = 2'd3
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BIN_WIDTH = 2'd0,
    CFG_PEAK_LOW  = 2'd1,
    CFG_PEAK_HIGH = 2'd2,
    CFG_BINS_USED = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]           opcode;
    logic [ENERGY_W-1:0]  energy;
    logic [BIN_IDX_W-1:0] bin_index;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   event_count;
    logic [COUNT_W-1:0]   deposit_count;
    logic [COUNT_W-1:0]   peak_count;
    logic [COUNT_W-1:0]   bin_value;
    logic [BIN_IDX_W-1:0] filled_bin;
    logic                 bin_filled;
    logic                 in_peak;
  } out_word_t;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + COUNT_W'(1);
  endfunction

endpackage

>>> rtl/phh_divider.sv
// Restoring divider, one quotient bit per cycle through a single subtractor.
module phh_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [phh_pkg::SUM_W-1:0]   dividend_i,
  input  logic [phh_pkg::BW_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [phh_pkg::SUM_W-1:0]   quot_o
);
  import phh_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [BW_W-1:0]  rem_q, rem_d;
  logic [BW_W-1:0]  div_q, div_d;
  logic [SUM_W-1:0] quo_q, quo_d;

  logic [BW_W:0]    trial;
  logic [BW_W+1:0]  diff;
  logic             borrow;

  // shared subtract unit: trial remainder minus divisor
  assign trial  = {rem_q, quo_q[SUM_W-1]};
  assign diff   = {1'b0, trial} - {2'b00, div_q};
  assign borrow = diff[BW_W+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(SUM_W - 1);
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = dividend_i;
    end else if (busy_q) begin
      // trial < divisor on borrow, so the low bits hold the whole remainder
      rem_d = borrow ? trial[BW_W-1:0] : diff[BW_W-1:0];
      quo_d = {quo_q[SUM_W-2:0], ~borrow};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

>>> rtl/phh_hist_ram.sv
// Single-port histogram memory with registered read data.
module phh_hist_ram #(
  parameter int unsigned NUM_BINS = phh_pkg::NUM_BINS_DEF
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic                        we_i,
  input  logic [$clog2(NUM_BINS)-1:0] addr_i,
  input  logic [phh_pkg::COUNT_W-1:0] wdata_i,
  output logic [phh_pkg::COUNT_W-1:0] rdata_o
);
  import phh_pkg::*;

  logic [COUNT_W-1:0] mem_q [NUM_BINS];
  logic [COUNT_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/pulse_height_histogrammer_core.sv
// Pulse-height analyzer: event energy sum, event counters and a bin histogram.
// Sequence per word: begin, add, an out-of-range read and an end of event with a zero sum
// or zero bin width go straight to the result register; an in-range read reads the bin;
// an end of event that divides runs the divider, then a read-modify-write of the bin, or
// skips the bin if it lies past the live range. One word in work at a time: the next is
// taken at best on the edge that accepts the result, and also while that result stalls.
// Reset: async, active low; a clearing pass then zeroes the histogram, no input word taken meanwhile.
module pulse_height_histogrammer_core #(
  parameter int unsigned NUM_BINS = phh_pkg::NUM_BINS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [phh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [phh_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  // input words
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  phh_pkg::in_word_t              in_data_i,
  // result words
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output phh_pkg::out_word_t             out_data_o
);
  import phh_pkg::*;

  localparam int unsigned AW = $clog2(NUM_BINS);

  // sequencer, one-hot
  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_DIV   = 6'b000100,
    S_READ  = 6'b001000,
    S_INC   = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [BW_W-1:0]        bin_width_q;
  logic [SUM_W-1:0]       peak_low_q;
  logic [SUM_W-1:0]       peak_high_q;
  logic [BINS_USED_W-1:0] bins_used_q;

  // architectural state
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic [COUNT_W-1:0] events_q, events_d;
  logic [COUNT_W-1:0] deps_q, deps_d;
  logic [COUNT_W-1:0] peaks_q, peaks_d;

  // per-word working registers
  op_e                  op_q, op_d;
  logic [AW-1:0]        addr_q, addr_d;
  logic [AW-1:0]        clr_q, clr_d;
  logic [BIN_IDX_W-1:0] fbin_q, fbin_d;
  logic                 filled_q, filled_d;
  logic                 in_peak_q, in_peak_d;
  logic                 rd_hit_q, rd_hit_d;

  // result register
  out_word_t out_q, out_d;
  logic      out_valid_q, out_valid_d;
  logic      out_load;

  logic               in_acc;
  logic [SUM_W:0]     sum_add;
  logic               div_start;
  logic               div_done;
  logic [SUM_W-1:0]   quot;
  logic               bin_ok;
  logic               ram_en, ram_we;
  logic [AW-1:0]      ram_addr;
  logic [COUNT_W-1:0] ram_wdata, ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign sum_add    = {1'b0, sum_q} + (SUM_W + 1)'(in_data_i.energy);
  assign bin_ok     = (quot < (SUM_W)'(bins_used_q)) && (quot < (SUM_W)'(NUM_BINS));

  // config writes land at any time; the host must write only while idle, the block does not enforce it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bin_width_q <= BIN_WIDTH_RST;
      peak_low_q  <= PEAK_LOW_RST;
      peak_high_q <= PEAK_HIGH_RST;
      bins_used_q <= BINS_USED_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BIN_WIDTH: bin_width_q <= cfg_wdata_i[BW_W-1:0];
        CFG_PEAK_LOW:  peak_low_q  <= cfg_wdata_i[SUM_W-1:0];
        CFG_PEAK_HIGH: peak_high_q <= cfg_wdata_i[SUM_W-1:0];
        CFG_BINS_USED: bins_used_q <= cfg_wdata_i[BINS_USED_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    events_d  = events_q;
    deps_d    = deps_q;
    peaks_d   = peaks_q;
    op_d      = op_q;
    addr_d    = addr_q;
    clr_d     = clr_q;
    fbin_d    = fbin_q;
    filled_d  = filled_q;
    in_peak_d = in_peak_q;
    rd_hit_d  = rd_hit_q;
    div_start = 1'b0;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = sat_inc(ram_rdata);
    out_load  = 1'b0;

    case (state_q)
      S_CLEAR: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(NUM_BINS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          op_d      = op_e'(in_data_i.opcode);
          fbin_d    = '0;
          filled_d  = 1'b0;
          in_peak_d = 1'b0;
          rd_hit_d  = 1'b0;
          state_d   = S_DONE;
          case (op_e'(in_data_i.opcode))
            OP_BEGIN: sum_d = '0;
            OP_ADD:   sum_d = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
            OP_END: begin
              events_d = sat_inc(events_q);
              if (sum_q != '0) begin
                deps_d = sat_inc(deps_q);
                if (sum_q >= peak_low_q && sum_q <= peak_high_q) begin
                  peaks_d   = sat_inc(peaks_q);
                  in_peak_d = 1'b1;
                end
                if (bin_width_q != '0) begin
                  div_start = 1'b1;
                  state_d   = S_DIV;
                end
              end
            end
            OP_READ: begin
              addr_d = AW'(in_data_i.bin_index);
              if ((COUNT_W)'(in_data_i.bin_index) < (COUNT_W)'(NUM_BINS)) begin
                rd_hit_d = 1'b1;
                state_d  = S_READ;
              end
            end
            default: ;
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          if (bin_ok) begin
            addr_d   = AW'(quot);
            fbin_d   = quot[BIN_IDX_W-1:0];
            filled_d = 1'b1;
            state_d  = S_READ;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_READ: begin
        ram_en  = 1'b1;
        state_d = (op_q == OP_END) ? S_INC : S_DONE;
      end
      S_INC: begin
        // read-modify-write, count saturates
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result word snapshot, counters already hold their post-step values
  always_comb begin
    out_d               = out_q;
    out_valid_d         = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d         = 1'b1;
      out_d.event_count   = events_q;
      out_d.deposit_count = deps_q;
      out_d.peak_count    = peaks_q;
      out_d.bin_value     = (op_q == OP_READ && rd_hit_q) ? ram_rdata : '0;
      out_d.filled_bin    = fbin_q;
      out_d.bin_filled    = filled_q;
      out_d.in_peak       = in_peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      sum_q       <= '0;
      events_q    <= '0;
      deps_q      <= '0;
      peaks_q     <= '0;
      op_q        <= OP_BEGIN;
      filled_q    <= 1'b0;
      in_peak_q   <= 1'b0;
      rd_hit_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      sum_q       <= sum_d;
      events_q    <= events_d;
      deps_q      <= deps_d;
      peaks_q     <= peaks_d;
      op_q        <= op_d;
      filled_q    <= filled_d;
      in_peak_q   <= in_peak_d;
      rd_hit_q    <= rd_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    fbin_q <= fbin_d;
    out_q  <= out_d;
  end

  phh_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (bin_width_q),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  phh_hist_ram #(
    .NUM_BINS (NUM_BINS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/phh_checker.sv
// Port-level checks for the pulse-height histogrammer, bound to the top level.
module phh_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input phh_pkg::in_word_t  in_data_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input phh_pkg::out_word_t out_data_o
);
  import phh_pkg::*;

  // a stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word changed while stalled");

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed while stalled");

  // every deposit is an ended event, every peak hit a deposit
  a_count_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.deposit_count <= out_data_o.event_count) &&
                    (out_data_o.peak_count <= out_data_o.deposit_count))
    else $error("counter ordering broken");

  // a filled bin or a peak hit comes from a nonzero event, never from a read
  a_fill_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.bin_filled || out_data_o.in_peak) |->
      out_data_o.deposit_count != '0 && out_data_o.bin_value == '0)
    else $error("fill or peak flag on a word that cannot carry it");

  a_fill_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.bin_filled |-> out_data_o.filled_bin == '0)
    else $error("filled bin index without a fill");

endmodule

bind pulse_height_histogrammer_core phh_checker u_phh_checker (.*);
